// ----- sv/rmq_pkg.sv -----
package rmq_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 18;
  localparam int OUT_W     = 18;
  // Radicand: one + d_k - d_i - d_j stays below 2^19 for 18-bit entries
  localparam int RAD_W     = IN_W + 1;
  localparam int ROOT_W    = (RAD_W + FRAC_BITS + 1) / 2;
  localparam int V_W       = 2 * ROOT_W;
  localparam int NUM_W     = IN_W + 1;
  localparam int QB        = OUT_W - 1;
  localparam int DN_A      = NUM_W + FRAC_BITS;
  localparam int DN_B      = ROOT_W + QB + 1;
  localparam int DN_W      = (DN_A > DN_B) ? DN_A : DN_B;
  localparam int LANES     = 3;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_X     = 2'd1;
  localparam logic [1:0] BR_Y     = 2'd2;
  localparam logic [1:0] BR_Z     = 2'd3;

  typedef logic signed [NUM_W-1:0] num_t;

  typedef struct packed {
    logic [ROOT_W+1:0]     rem;
    logic [ROOT_W-1:0]     root;
    logic [V_W-1:0]        vsh;
    logic [1:0]            br;
    num_t [LANES-1:0]      num;
  } sqrt_stage_t;

  typedef struct packed {
    logic [LANES-1:0][DN_W-1:0] rem;
    logic [DN_W-1:0]            dsh;
    logic [LANES-1:0][QB-1:0]   q;
    logic [LANES-1:0]           neg;
    logic [LANES-1:0]           ovf;
    logic [OUT_W-1:0]           half;
    logic [1:0]                 br;
  } div_stage_t;

endpackage

// ----- sv/rotation_matrix_to_quaternion_core.sv -----
// Pipeline from input transaction to result valid: 1 set-up stage,
// 18 root cells, 1 divide set-up stage, 17 divide cells, 1 output register.
// Throughput: one transaction per cycle while the output is not stalled; every stage is a cell of the chain.
// Reset: synchronous, active high; clears every stage valid, payload unreset.
module rotation_matrix_to_quaternion_core import rmq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [IN_W-1:0]  r00,
  input  logic signed [IN_W-1:0]  r01,
  input  logic signed [IN_W-1:0]  r02,
  input  logic signed [IN_W-1:0]  r10,
  input  logic signed [IN_W-1:0]  r11,
  input  logic signed [IN_W-1:0]  r12,
  input  logic signed [IN_W-1:0]  r20,
  input  logic signed [IN_W-1:0]  r21,
  input  logic signed [IN_W-1:0]  r22,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] quat_w,
  output logic signed [OUT_W-1:0] quat_x,
  output logic signed [OUT_W-1:0] quat_y,
  output logic signed [OUT_W-1:0] quat_z,
  output logic [1:0]              branch_used
);

  // Stage map: 0 set-up, 1..ROOT_W root cells, then divide set-up,
  // then QB divide cells, then the output register.
  localparam int DP   = ROOT_W + 1;
  localparam int OS   = DP + QB + 1;
  localparam int NST  = OS + 1;

  logic [NST:0]   adv;
  wire  [NST-1:0] v;
  logic           v_setup;
  logic           v_dsetup;
  logic           v_out;

  assign v[0]  = v_setup;
  assign v[DP] = v_dsetup;
  assign v[OS] = v_out;

  // A stage advances when it is empty or the stage after it advances
  assign adv[NST] = out_ready;
  for (genvar i = 0; i < NST; i++) begin : g_adv
    assign adv[i] = ~v[i] | adv[i+1];
  end
  assign in_ready  = adv[0];
  assign out_valid = v[OS];

  // ---------------- set-up stage: branch, radicand, numerators ----------
  sqrt_stage_t sq_in;
  sqrt_stage_t sq_in_next;
  logic signed [IN_W+2:0] tr;
  logic signed [IN_W+2:0] rad;
  logic signed [IN_W+2:0] one;
  logic [RAD_W-1:0]       rad_c;
  num_t d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;

  always_comb begin
    one    = (IN_W+3)'(1) <<< FRAC_BITS;
    tr     = (IN_W+3)'(r00) + (IN_W+3)'(r11) + (IN_W+3)'(r22);
    d21_12 = NUM_W'(r21) - NUM_W'(r12);
    d02_20 = NUM_W'(r02) - NUM_W'(r20);
    d10_01 = NUM_W'(r10) - NUM_W'(r01);
    s01_10 = NUM_W'(r01) + NUM_W'(r10);
    s02_20 = NUM_W'(r02) + NUM_W'(r20);
    s12_21 = NUM_W'(r12) + NUM_W'(r21);
    sq_in_next = '0;
    if (tr > 0) begin
      sq_in_next.br  = BR_TRACE;
      rad            = tr + one;
      sq_in_next.num = {d10_01, d02_20, d21_12};
    end else if (r00 > r11 && r00 > r22) begin
      sq_in_next.br  = BR_X;
      rad            = one + (IN_W+3)'(r00) - (IN_W+3)'(r11) - (IN_W+3)'(r22);
      sq_in_next.num = {s02_20, s01_10, d21_12};
    end else if (r11 > r22) begin
      sq_in_next.br  = BR_Y;
      rad            = one + (IN_W+3)'(r11) - (IN_W+3)'(r00) - (IN_W+3)'(r22);
      sq_in_next.num = {s12_21, s01_10, d02_20};
    end else begin
      sq_in_next.br  = BR_Z;
      rad            = one + (IN_W+3)'(r22) - (IN_W+3)'(r00) - (IN_W+3)'(r11);
      sq_in_next.num = {s12_21, s02_20, d10_01};
    end
    // Clamp a non-positive radicand to one LSB
    rad_c          = (rad < 1) ? RAD_W'(1) : rad[RAD_W-1:0];
    sq_in_next.vsh = V_W'(rad_c) << FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_setup <= 1'b0;
    end else if (adv[0]) begin
      v_setup <= in_valid;
    end
    if (adv[0]) begin
      sq_in <= sq_in_next;
    end
  end

  // ---------------- root chain -------------------------------------------
  sqrt_stage_t sq_d [0:ROOT_W];
  assign sq_d[0] = sq_in;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    rmq_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv[i+1]),
      .din_valid (v[i]),
      .din       (sq_d[i]),
      .dout_valid(v[i+1]),
      .dout      (sq_d[i+1])
    );
  end

  // ---------------- divide set-up ----------------------------------------
  div_stage_t dv_in;
  div_stage_t dv_in_next;
  sqrt_stage_t sq_o;
  logic [NUM_W-1:0]  mag;
  logic [DN_W-1:0]   nfull;
  logic [DN_W+1:0]   dlim;
  logic [ROOT_W:0]   hp;
  logic [ROOT_W-1:0] hv;

  assign sq_o = sq_d[ROOT_W];

  always_comb begin
    dv_in_next     = '0;
    dv_in_next.br  = sq_o.br;
    dv_in_next.dsh = DN_W'(sq_o.root) << QB;
    // Quotients of 2^QB and above saturate
    dlim = (DN_W+2)'(sq_o.root) << (QB + 1);
    for (int k = 0; k < LANES; k++) begin
      dv_in_next.neg[k] = sq_o.num[k][NUM_W-1];
      // Keep the full magnitude: the most negative sum needs every bit
      mag   = sq_o.num[k][NUM_W-1] ? (~sq_o.num[k] + NUM_W'(1)) : sq_o.num[k];
      nfull = (DN_W'(mag) << FRAC_BITS) + DN_W'(sq_o.root);
      dv_in_next.rem[k] = nfull;
      dv_in_next.ovf[k] = ((DN_W+2)'(nfull) >= dlim);
    end
    hp = {1'b0, sq_o.root} + (ROOT_W+1)'(1);
    hv = hp[ROOT_W:1];
    if (32'(hv) > 32'(OUT_MAX)) begin
      dv_in_next.half = OUT_MAX;
    end else begin
      dv_in_next.half = OUT_W'(hv);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_dsetup <= 1'b0;
    end else if (adv[DP]) begin
      v_dsetup <= v[DP-1];
    end
    if (adv[DP]) begin
      dv_in <= dv_in_next;
    end
  end

  // ---------------- divide chain -----------------------------------------
  div_stage_t dv_d [0:QB];
  assign dv_d[0] = dv_in;

  for (genvar i = 0; i < QB; i++) begin : g_div
    rmq_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv[DP+i+1]),
      .din_valid (v[DP+i]),
      .din       (dv_d[i]),
      .dout_valid(v[DP+i+1]),
      .dout      (dv_d[i+1])
    );
  end

  // ---------------- sign, saturate, place lanes --------------------------
  div_stage_t dv_o;
  logic signed [OUT_W-1:0] lane [LANES];
  logic signed [OUT_W-1:0] qext;
  logic signed [OUT_W-1:0] w_next, x_next, y_next, z_next;

  assign dv_o = dv_d[QB];

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      qext = {1'b0, dv_o.q[k]};
      if (dv_o.ovf[k]) begin
        lane[k] = dv_o.neg[k] ? OUT_MIN : OUT_MAX;
      end else begin
        lane[k] = dv_o.neg[k] ? -qext : qext;
      end
    end
    unique case (dv_o.br)
      BR_TRACE: begin
        w_next = dv_o.half; x_next = lane[0]; y_next = lane[1]; z_next = lane[2];
      end
      BR_X: begin
        w_next = lane[0]; x_next = dv_o.half; y_next = lane[1]; z_next = lane[2];
      end
      BR_Y: begin
        w_next = lane[0]; x_next = lane[1]; y_next = dv_o.half; z_next = lane[2];
      end
      default: begin
        w_next = lane[0]; x_next = lane[1]; y_next = lane[2]; z_next = dv_o.half;
      end
    endcase
  end

  // Output register: hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (adv[OS]) begin
      v_out <= v[OS-1];
    end
    if (adv[OS]) begin
      quat_w      <= w_next;
      quat_x      <= x_next;
      quat_y      <= y_next;
      quat_z      <= z_next;
      branch_used <= dv_o.br;
    end
  end

endmodule

// ----- sv/rmq_sqrt_cell.sv -----
module rmq_sqrt_cell import rmq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        din_valid,
  input  sqrt_stage_t din,
  output logic        dout_valid,
  output sqrt_stage_t dout
);

  sqrt_stage_t dout_next;
  logic [ROOT_W+3:0] acc;
  logic [ROOT_W+3:0] trial;
  logic [ROOT_W+3:0] diff;

  // One root bit per cell: bring down two radicand bits, try the subtract
  always_comb begin
    acc   = {din.rem, din.vsh[V_W-1 -: 2]};
    trial = {2'b00, din.root, 2'b01};
    diff  = acc - trial;
    dout_next     = din;
    dout_next.vsh = {din.vsh[V_W-3:0], 2'b00};
    if (acc >= trial) begin
      dout_next.rem  = diff[ROOT_W+1:0];
      dout_next.root = {din.root[ROOT_W-2:0], 1'b1};
    end else begin
      dout_next.rem  = acc[ROOT_W+1:0];
      dout_next.root = {din.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout_valid <= 1'b0;
    end else if (adv) begin
      dout_valid <= din_valid;
    end
    if (adv) begin
      dout <= dout_next;
    end
  end

endmodule

// ----- sv/rmq_div_cell.sv -----
module rmq_div_cell import rmq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  logic       din_valid,
  input  div_stage_t din,
  output logic       dout_valid,
  output div_stage_t dout
);

  div_stage_t dout_next;

  // One quotient bit per lane per cell; the divisor shifts down a place
  always_comb begin
    dout_next     = din;
    dout_next.dsh = din.dsh >> 1;
    for (int k = 0; k < LANES; k++) begin
      if (din.rem[k] >= din.dsh) begin
        dout_next.rem[k] = din.rem[k] - din.dsh;
        dout_next.q[k]   = {din.q[k][QB-2:0], 1'b1};
      end else begin
        dout_next.q[k]   = {din.q[k][QB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout_valid <= 1'b0;
    end else if (adv) begin
      dout_valid <= din_valid;
    end
    if (adv) begin
      dout <= dout_next;
    end
  end

endmodule

// ----- sv/rmq_checker.sv -----
module rmq_checker import rmq_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [OUT_W-1:0] quat_w,
  input logic signed [OUT_W-1:0] quat_x,
  input logic signed [OUT_W-1:0] quat_y,
  input logic signed [OUT_W-1:0] quat_z,
  input logic [1:0]              branch_used
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(quat_w) && $stable(quat_x)
      && $stable(quat_y) && $stable(quat_z) && $stable(branch_used))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

  a_diag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (branch_used == BR_TRACE && !quat_w[OUT_W-1])
      || (branch_used == BR_X && !quat_x[OUT_W-1])
      || (branch_used == BR_Y && !quat_y[OUT_W-1])
      || (branch_used == BR_Z && !quat_z[OUT_W-1]))
    else $error("diagonal component negative");

endmodule

bind rotation_matrix_to_quaternion_core rmq_checker u_rmq_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .quat_w     (quat_w),
  .quat_x     (quat_x),
  .quat_y     (quat_y),
  .quat_z     (quat_z),
  .branch_used(branch_used)
);

// ----- bench/rotation_matrix_to_quaternion_core_tb.sv -----
module rotation_matrix_to_quaternion_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rmq_pkg::*;

  // One matrix transaction and one quaternion transaction
  typedef struct packed {
    logic signed [IN_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } matrix_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] w, x, y, z;
    logic [1:0]              br;
  } quat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [IN_W-1:0] r00 = '0, r01 = '0, r02 = '0, r10 = '0, r11 = '0;
  logic signed [IN_W-1:0] r12 = '0, r20 = '0, r21 = '0, r22 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] quat_w, quat_x, quat_y, quat_z;
  logic [1:0] branch_used;

  matrix_t pending_mats[$];
  quat_t   expected_quats[$];
  int      error_count = 0;
  int      send_idle_pct = 23;
  int      recv_idle_pct = 58;
  bit      hold_sender = 1'b0;

  always #1 clk = ~clk;

  rotation_matrix_to_quaternion_core u_top (.*);

  // Integer square root, rounded down
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint clip18(longint v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return v;
  endfunction

  // Root of a radicand clamped to one LSB
  function automatic longint unsigned radicand_root(longint rad);
    if (rad < 1) rad = 1;
    return int_sqrt(longint'(rad) << FRAC_BITS);
  endfunction

  // n / (2*root), magnitude rounded half away from zero
  function automatic longint scaled_quotient(longint n, longint unsigned root);
    longint unsigned d, m, q;
    d = root << 1;
    m = (n < 0) ? -n : n;
    q = ((m << FRAC_BITS) + (d >> 1)) / d;
    return clip18(n < 0 ? -longint'(q) : longint'(q));
  endfunction

  function automatic longint half_of_root(longint unsigned root);
    return clip18(longint'((root + 1) >> 1));
  endfunction

  function automatic quat_t shepperd_quat(matrix_t m);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22, one, tr;
    longint unsigned root;
    quat_t q;
    a00 = m.m00; a01 = m.m01; a02 = m.m02;
    a10 = m.m10; a11 = m.m11; a12 = m.m12;
    a20 = m.m20; a21 = m.m21; a22 = m.m22;
    one = longint'(1) << FRAC_BITS;
    tr = a00 + a11 + a22;
    if (tr > 0) begin
      root = radicand_root(tr + one);
      q.br = BR_TRACE;
      q.w = OUT_W'(half_of_root(root));
      q.x = OUT_W'(scaled_quotient(a21 - a12, root));
      q.y = OUT_W'(scaled_quotient(a02 - a20, root));
      q.z = OUT_W'(scaled_quotient(a10 - a01, root));
    end else if (a00 > a11 && a00 > a22) begin
      root = radicand_root(one + a00 - a11 - a22);
      q.br = BR_X;
      q.w = OUT_W'(scaled_quotient(a21 - a12, root));
      q.x = OUT_W'(half_of_root(root));
      q.y = OUT_W'(scaled_quotient(a01 + a10, root));
      q.z = OUT_W'(scaled_quotient(a02 + a20, root));
    end else if (a11 > a22) begin
      root = radicand_root(one + a11 - a00 - a22);
      q.br = BR_Y;
      q.w = OUT_W'(scaled_quotient(a02 - a20, root));
      q.x = OUT_W'(scaled_quotient(a01 + a10, root));
      q.y = OUT_W'(half_of_root(root));
      q.z = OUT_W'(scaled_quotient(a12 + a21, root));
    end else begin
      root = radicand_root(one + a22 - a00 - a11);
      q.br = BR_Z;
      q.w = OUT_W'(scaled_quotient(a10 - a01, root));
      q.x = OUT_W'(scaled_quotient(a02 + a20, root));
      q.y = OUT_W'(scaled_quotient(a12 + a21, root));
      q.z = OUT_W'(half_of_root(root));
    end
    return q;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Driver: hold the payload until the transaction is taken, then advance
  always @(posedge clk) begin
    if (!rst) begin
      if (!in_valid || in_ready) begin
        if (pending_mats.size() > 0 && !hold_sender &&
            $urandom_range(99) >= send_idle_pct) begin
          matrix_t m;
          m = pending_mats.pop_front();
          expected_quats.push_back(shepperd_quat(m));
          in_valid <= 1'b1;
          {r00, r01, r02, r10, r11, r12, r20, r21, r22} <= m;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: compare each quaternion with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_quats.size() == 0) begin
        report_mismatch("unexpected transaction", 0, 0);
      end else begin
        quat_t e;
        e = expected_quats.pop_front();
        if (quat_w !== e.w) report_mismatch("quat_w", quat_w, e.w);
        if (quat_x !== e.x) report_mismatch("quat_x", quat_x, e.x);
        if (quat_y !== e.y) report_mismatch("quat_y", quat_y, e.y);
        if (quat_z !== e.z) report_mismatch("quat_z", quat_z, e.z);
        if (branch_used !== e.br) report_mismatch("branch_used", branch_used, e.br);
      end
    end
  end

  // Entry in [-1, 1]
  function automatic logic signed [IN_W-1:0] rand_near();
    return IN_W'(int'($urandom_range(131072)) - 65536);
  endfunction

  function automatic logic signed [IN_W-1:0] rand_entry();
    case ($urandom_range(5))
      0: return IN_W'(-131072);
      1: return IN_W'(131071);
      2: return rand_near();
      default: return IN_W'($urandom());
    endcase
  endfunction

  // Mostly: diagonal and m01, m10, m12 in [-1,1], m02, m20, m21 from rand_entry
  function automatic matrix_t rand_matrix();
    matrix_t m;
    logic [191:0] bits;
    bits = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    m = bits[161:0];
    if ($urandom_range(3) != 0) begin
      m.m00 = rand_near();
      m.m11 = rand_near();
      m.m22 = rand_near();
      m.m01 = rand_near();
      m.m10 = rand_near();
      m.m02 = rand_entry();
      m.m20 = rand_entry();
      m.m12 = rand_near();
      m.m21 = rand_entry();
    end
    return m;
  endfunction

  task automatic wait_drained();
    while (pending_mats.size() > 0 || in_valid || expected_quats.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    matrix_t m;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: identity, each branch, ties, zero trace, extremes
    pending_mats.push_back({18'sd65536, 18'sd0, 18'sd0, 18'sd0, 18'sd65536, 18'sd0,
                            18'sd0, 18'sd0, 18'sd65536});
    pending_mats.push_back({18'sd65536, 18'sd0, 18'sd0, 18'sd0, -18'sd65536, 18'sd0,
                            18'sd0, 18'sd0, -18'sd65536});
    pending_mats.push_back({-18'sd65536, 18'sd0, 18'sd0, 18'sd0, 18'sd65536, 18'sd0,
                            18'sd0, 18'sd0, -18'sd65536});
    pending_mats.push_back({-18'sd65536, 18'sd0, 18'sd0, 18'sd0, -18'sd65536, 18'sd0,
                            18'sd0, 18'sd0, 18'sd65536});
    // Equal diagonals: falls through to z; x tie with y picks y
    pending_mats.push_back({-18'sd1000, 18'sd5, 18'sd7, 18'sd9, -18'sd1000, 18'sd3,
                            18'sd1, 18'sd2, -18'sd1000});
    pending_mats.push_back({18'sd0, 18'sd5, 18'sd7, 18'sd9, 18'sd0, 18'sd3,
                            18'sd1, 18'sd2, -18'sd5000});
    // Zero trace exactly, then extreme entries
    pending_mats.push_back({18'sd0, 18'sd100, -18'sd100, 18'sd50, 18'sd0, 18'sd7,
                            18'sd9, -18'sd3, 18'sd0});
    pending_mats.push_back({-18'sd131072, 18'sd131071, 18'sd131071, -18'sd131072,
                            18'sd131071, -18'sd131072, 18'sd131071, -18'sd131072,
                            18'sd131071});
    pending_mats.push_back({18'sd131071, -18'sd131072, 18'sd131071, 18'sd131071,
                            18'sd131071, 18'sd131071, -18'sd131072, 18'sd131071,
                            18'sd131071});
    pending_mats.push_back({9{-18'sd131072}});
    pending_mats.push_back({9{18'sd131071}});
    pending_mats.push_back('0);
    pending_mats.push_back({9{18'sd1}});
    pending_mats.push_back({9{-18'sd1}});
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 58 : 0;
      recv_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 23 : 0;
      for (int i = 0; i < 660; i++) begin
        m = rand_matrix();
        pending_mats.push_back(m);
        // Hold the sender once until the pipeline has emptied
        if (phase == 1 && i == 300) begin
          while (pending_mats.size() > 0) @(posedge clk);
          hold_sender = 1'b1;
          while (in_valid || expected_quats.size() > 0) @(posedge clk);
          hold_sender = 1'b0;
        end
        // Quiet stretch with no idling inside the first phase
        if (phase == 0 && i == 400) begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end else if (phase == 0 && i == 500) begin
          send_idle_pct = 23;
          recv_idle_pct = 58;
        end
      end
      wait_drained();
    end

    repeat (60) @(posedge clk);
    if (error_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #400us;
    $display("FAILURE");
    $finish;
  end

endmodule
